/* design/gcti_pkg.sv */
// Shared constants and codes of the gain curve table interpolator.
// Depends on nothing; used by the divider and the top level.
package gcti_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned DataW      = 32;
  localparam int unsigned WideW      = 64;

  localparam logic [WideW-1:0] SlopeCap = 64'h4000_0000_0000_0000;
  localparam logic [WideW-1:0] WideMax  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdAppend = 2'd1,
    CmdLinear = 2'd2,
    CmdCubic  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatFull  = 2'd1,
    StatOrder = 2'd2
  } status_e;

endpackage

/* design/gcti_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read data.
// Depends on nothing.
module gcti_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/gcti_div.sv */
// Bit-serial restoring divider, one quotient bit a cycle, rounded half up.
// Depends on gcti_pkg for the operand width.
module gcti_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gcti_pkg::WideW-1:0] num_i,
  input  logic [gcti_pkg::WideW-1:0] den_i,
  output logic                       done_o,
  output logic [gcti_pkg::WideW-1:0] quot_o
);

  localparam int unsigned W     = gcti_pkg::WideW;
  localparam int unsigned StepW = $clog2(W);

  logic             run_q, fin_q;
  logic [StepW-1:0] step_q;
  logic [W:0]       rem_q;
  logic [W-1:0]     quo_q, den_q;
  logic [W:0]       rem_sh, rem_sub;
  logic             fits;
  logic             round_up;

  assign rem_sh   = {rem_q[W-1:0], quo_q[W-1]};
  assign fits     = rem_sh >= {1'b0, den_q};
  assign rem_sub  = rem_sh - {1'b0, den_q};
  assign round_up = rem_q[W-1:0] >= (den_q - rem_q[W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        fin_q  <= 1'b0;
        step_q <= '0;
        rem_q  <= '0;
        quo_q  <= num_i;
        den_q  <= den_i;
      end else if (run_q) begin
        rem_q  <= fits ? rem_sub : rem_sh;
        quo_q  <= {quo_q[W-2:0], fits};
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(W - 1)) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end
      end else if (fin_q) begin
        quot_o <= quo_q + W'(round_up);
        done_o <= 1'b1;
        fin_q  <= 1'b0;
      end
    end
  end

endmodule

/* design/gain_curve_table_interpolator.sv */
// Gain curve table with linear and cubic Hermite queries.
// Depends on gcti_pkg, gcti_ram (frequency and gain tables) and gcti_div.
//
// Usage: drive command_i, freq_i and gain_i with start high; the command is
// taken at a rising edge where start is high and busy is low. Every command
// gives one result: valid_o is high for exactly one cycle with value_o,
// status_o and error_seen_o, and that cycle is the transfer; nothing holds
// it off.
// Clear, append, and queries at or beyond either end of the table or on an empty
// table answer in the cycle after the transfer, with busy staying low, so they
// may be issued every cycle.
// Queries inside the table raise busy: a binary search over the frequency RAM,
// neighbor reads (two for linear, four for cubic), then the shared serial divider.
// Linear uses one division; cubic up to five divisions and three multiply passes.
// Reset empties the table and clears the error flag; RAM contents stay
// undefined, and neighbor reads past either end of the table go unused.
module gain_curve_table_interpolator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command_i,
  input  logic [31:0] freq_i,
  input  logic [31:0] gain_i,
  output logic        valid_o,
  output logic [31:0] value_o,
  output logic [1:0]  status_o,
  output logic        error_seen_o
);

  localparam int unsigned AW = gcti_pkg::AddrW;
  localparam int unsigned CW = gcti_pkg::CntW;
  localparam int unsigned W  = gcti_pkg::WideW;

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CK, S_FETCH, S_GRAB,
    S_LIN0, S_LIN1, S_LIN2, S_LINF, S_DIVW,
    S_C0, S_C1, S_C2, S_C3, S_C4,
    S_T0, S_T1, S_T2, S_T4, S_P0, S_P1,
    S_M0, S_M1, S_M2, S_FIN
  } state_e;

  function automatic logic [W-1:0] mag64(input logic [W-1:0] v);
    mag64 = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [W-1:0] signcap(input logic [W-1:0] m, input logic neg,
                                           input logic [W-1:0] cap);
    logic [W-1:0] mm;
    mm = (m > cap) ? cap : m;
    signcap = neg ? (~mm + 1'b1) : mm;
  endfunction

  function automatic logic [31:0] sat32(input logic [W-1:0] v);
    logic signed [W-1:0] s;
    s = v;
    if (s > 64'sh7FFF_FFFF) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (s < -64'sh8000_0000) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  state_e              state_q, ret_q;
  logic [CW-1:0]       cnt_q;
  logic                err_q;
  logic signed [31:0]  first_f_q, first_g_q, last_f_q, last_g_q, qf_q;
  logic                cubic_q, tsel_q, neg_q;
  logic [AW-1:0]       lo_q, hi_q, mid, raddr;
  logic [1:0]          k_q, pass_q;
  logic signed [31:0]  fv_q [4];
  logic signed [31:0]  gv_q [4];
  logic [W-1:0]        prod_q, acc_q, x_q, s_q;
  logic [W-1:0]        m0_q, m1_q, m2_q, t0_q, t1_q, ca_q, cb_q, h_q;
  logic [31:0]         xq_q;
  logic                div_go_q, div_done;
  logic [W-1:0]        div_num_q, div_den_q, div_quot;
  logic [31:0]         f_rdata, g_rdata;
  logic                accept, app_ok, we;

  logic [31:0]         unit, d0, d1, dfl, dfr;
  logic signed [32:0]  dgl, dgr;
  logic [32:0]         magl, magr;
  logic [W-1:0]        tp, tq, ta, tb, tx, hm, num_lin, r_m;
  logic [CW:0]         ip2;
  logic                has_left, has_right, tzero;
  logic signed [33:0]  mul_a, mul_b;
  logic signed [67:0]  mul_p;

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign app_ok  = (cnt_q < CW'(gcti_pkg::TableDepth)) &&
                   ((cnt_q == '0) || ($signed(freq_i) > last_f_q));
  assign we      = accept && (command_i == gcti_pkg::CmdAppend) && app_ok;
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);

  assign unit    = fv_q[1] - fv_q[0];
  assign d0      = qf_q - fv_q[0];
  assign d1      = fv_q[1] - qf_q;
  assign dfl     = fv_q[0] - fv_q[2];
  assign dfr     = fv_q[3] - fv_q[1];
  assign dgl     = 33'(gv_q[0]) - 33'(gv_q[2]);
  assign dgr     = 33'(gv_q[3]) - 33'(gv_q[1]);
  assign magl    = dgl[32] ? 33'(-dgl) : dgl;
  assign magr    = dgr[32] ? 33'(-dgr) : dgr;
  assign ip2     = (CW+1)'(lo_q) + (CW+1)'(2);
  assign has_left  = (lo_q != '0);
  assign has_right = ip2 < {1'b0, cnt_q};

  assign tp      = tsel_q ? m1_q : m0_q;
  assign tq      = tsel_q ? m2_q : m1_q;
  assign tzero   = (tp == '0) || (tq == '0) || (tp[W-1] != tq[W-1]);
  assign ta      = mag64(tp);
  assign tb      = mag64(tq);
  assign tx      = (ta < tb) ? ta : tb;
  assign hm      = mag64(h_q);
  assign num_lin = acc_q + prod_q;
  assign r_m     = prod_q + acc_q;

  always_comb begin
    raddr = mid;
    if (state_q == S_FETCH) begin
      unique case (k_q)
        2'd0: raddr = lo_q;
        2'd1: raddr = lo_q + 1'b1;
        2'd2: raddr = lo_q - 1'b1;
        2'd3: raddr = lo_q + AW'(2);
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_LIN0: begin
        mul_a = {2'b00, d0};
        mul_b = 34'(gv_q[1]);
      end
      S_LIN1: begin
        mul_a = {2'b00, d1};
        mul_b = 34'(gv_q[0]);
      end
      S_C0: begin
        mul_a = {1'b0, magl};
        mul_b = {2'b00, unit};
      end
      S_C2: begin
        mul_a = {1'b0, magr};
        mul_b = {2'b00, unit};
      end
      S_T0: begin
        mul_a = {2'b00, tx[31:0]};
        mul_b = {2'b00, tx[31:0]};
      end
      S_T1: begin
        mul_a = {2'b00, x_q[63:32]};
        mul_b = {2'b00, x_q[31:0]};
      end
      S_M0: begin
        mul_a = {2'b00, hm[31:0]};
        mul_b = {2'b00, xq_q};
      end
      S_M1: begin
        mul_a = {2'b00, hm[63:32]};
        mul_b = {2'b00, xq_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  gcti_ram #(.Width(gcti_pkg::DataW), .Depth(gcti_pkg::TableDepth)) u_freq_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (freq_i),
    .raddr_i (raddr),
    .rdata_o (f_rdata)
  );

  gcti_ram #(.Width(gcti_pkg::DataW), .Depth(gcti_pkg::TableDepth)) u_gain_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (gain_i),
    .raddr_i (raddr),
    .rdata_o (g_rdata)
  );

  gcti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      cnt_q    <= '0;
      err_q    <= 1'b0;
      valid_o  <= 1'b0;
      div_go_q <= 1'b0;
    end else begin
      valid_o  <= 1'b0;
      div_go_q <= 1'b0;
      prod_q   <= W'(mul_p);
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            unique case (gcti_pkg::cmd_e'(command_i))
              gcti_pkg::CmdClear: begin
                cnt_q        <= '0;
                err_q        <= 1'b0;
                valid_o      <= 1'b1;
                value_o      <= '0;
                status_o     <= gcti_pkg::StatOk;
                error_seen_o <= 1'b0;
              end
              gcti_pkg::CmdAppend: begin
                valid_o <= 1'b1;
                value_o <= '0;
                if (cnt_q >= CW'(gcti_pkg::TableDepth)) begin
                  err_q        <= 1'b1;
                  status_o     <= gcti_pkg::StatFull;
                  error_seen_o <= 1'b1;
                end else if (!app_ok) begin
                  err_q        <= 1'b1;
                  status_o     <= gcti_pkg::StatOrder;
                  error_seen_o <= 1'b1;
                end else begin
                  cnt_q        <= cnt_q + 1'b1;
                  last_f_q     <= freq_i;
                  last_g_q     <= gain_i;
                  if (cnt_q == '0) begin
                    first_f_q <= freq_i;
                    first_g_q <= gain_i;
                  end
                  status_o     <= gcti_pkg::StatOk;
                  error_seen_o <= err_q;
                end
              end
              gcti_pkg::CmdLinear, gcti_pkg::CmdCubic: begin
                status_o     <= gcti_pkg::StatOk;
                error_seen_o <= err_q;
                if (cnt_q == '0) begin
                  valid_o <= 1'b1;
                  value_o <= '0;
                end else if ($signed(freq_i) <= first_f_q) begin
                  valid_o <= 1'b1;
                  value_o <= first_g_q;
                end else if ($signed(freq_i) >= last_f_q) begin
                  valid_o <= 1'b1;
                  value_o <= last_g_q;
                end else begin
                  qf_q    <= freq_i;
                  cubic_q <= (command_i == gcti_pkg::CmdCubic);
                  lo_q    <= '0;
                  hi_q    <= AW'(cnt_q - 1'b1);
                  state_q <= S_SRCH_RD;
                end
              end
            endcase
          end
        end
        S_SRCH_RD: begin
          if ((hi_q - lo_q) > AW'(1)) begin
            state_q <= S_SRCH_CK;
          end else begin
            k_q     <= 2'd0;
            state_q <= S_FETCH;
          end
        end
        S_SRCH_CK: begin
          if ($signed(f_rdata) <= qf_q) begin
            lo_q <= mid;
          end else begin
            hi_q <= mid;
          end
          state_q <= S_SRCH_RD;
        end
        S_FETCH: begin
          state_q <= S_GRAB;
        end
        S_GRAB: begin
          fv_q[k_q] <= f_rdata;
          gv_q[k_q] <= g_rdata;
          if (k_q == (cubic_q ? 2'd3 : 2'd1)) begin
            state_q <= cubic_q ? S_C0 : S_LIN0;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_FETCH;
          end
        end
        S_LIN0: begin
          if (d0 == '0) begin
            valid_o <= 1'b1;
            value_o <= gv_q[0];
            state_q <= S_IDLE;
          end else begin
            state_q <= S_LIN1;
          end
        end
        S_LIN1: begin
          acc_q   <= prod_q;
          state_q <= S_LIN2;
        end
        S_LIN2: begin
          neg_q     <= num_lin[W-1];
          div_go_q  <= 1'b1;
          div_num_q <= mag64(num_lin);
          div_den_q <= W'(unit);
          ret_q     <= S_LINF;
          state_q   <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            state_q <= ret_q;
          end
        end
        S_LINF: begin
          valid_o <= 1'b1;
          value_o <= sat32(signcap(div_quot, neg_q, gcti_pkg::WideMax));
          state_q <= S_IDLE;
        end
        S_C0: begin
          m1_q    <= W'(gv_q[1]) - W'(gv_q[0]);
          state_q <= S_C1;
        end
        S_C1: begin
          div_go_q  <= 1'b1;
          div_num_q <= prod_q;
          div_den_q <= W'(dfl);
          ret_q     <= S_C2;
          state_q   <= S_DIVW;
        end
        S_C2: begin
          m0_q    <= has_left ? signcap(div_quot, dgl[32], gcti_pkg::SlopeCap) : '0;
          state_q <= S_C3;
        end
        S_C3: begin
          div_go_q  <= 1'b1;
          div_num_q <= prod_q;
          div_den_q <= W'(dfr);
          ret_q     <= S_C4;
          state_q   <= S_DIVW;
        end
        S_C4: begin
          m2_q    <= has_right ? signcap(div_quot, dgr[32], gcti_pkg::SlopeCap) : '0;
          tsel_q  <= 1'b0;
          state_q <= S_T0;
        end
        S_T0: begin
          if (tzero) begin
            if (tsel_q) begin
              t1_q    <= '0;
              state_q <= S_P0;
            end else begin
              t0_q   <= '0;
              tsel_q <= 1'b1;
            end
          end else begin
            x_q     <= tx;
            s_q     <= ta + tb;
            neg_q   <= tq[W-1];
            state_q <= S_T1;
          end
        end
        S_T1: begin
          acc_q   <= prod_q;
          state_q <= S_T2;
        end
        S_T2: begin
          div_go_q  <= 1'b1;
          div_num_q <= acc_q + (prod_q << 33);
          div_den_q <= s_q;
          ret_q     <= S_T4;
          state_q   <= S_DIVW;
        end
        S_T4: begin
          if (tsel_q) begin
            t1_q    <= signcap((x_q - div_quot) << 1, neg_q, gcti_pkg::SlopeCap);
            state_q <= S_P0;
          end else begin
            t0_q    <= signcap((x_q - div_quot) << 1, neg_q, gcti_pkg::SlopeCap);
            tsel_q  <= 1'b1;
            state_q <= S_T0;
          end
        end
        S_P0: begin
          ca_q      <= t0_q + t1_q - (m1_q << 1);
          cb_q      <= m1_q + (m1_q << 1) - t1_q - (t0_q << 1);
          div_go_q  <= 1'b1;
          div_num_q <= {d0, 32'h0};
          div_den_q <= W'(unit);
          ret_q     <= S_P1;
          state_q   <= S_DIVW;
        end
        S_P1: begin
          xq_q    <= div_quot[31:0];
          h_q     <= ca_q;
          pass_q  <= 2'd0;
          state_q <= S_M0;
        end
        S_M0: begin
          state_q <= S_M1;
        end
        S_M1: begin
          acc_q   <= (prod_q + W'(32'h8000_0000)) >> 32;
          state_q <= S_M2;
        end
        S_M2: begin
          if (pass_q == 2'd2) begin
            h_q     <= signcap(r_m, h_q[W-1], gcti_pkg::WideMax);
            state_q <= S_FIN;
          end else begin
            h_q     <= signcap(r_m, h_q[W-1], gcti_pkg::WideMax) +
                       ((pass_q == 2'd0) ? cb_q : t0_q);
            pass_q  <= pass_q + 1'b1;
            state_q <= S_M0;
          end
        end
        S_FIN: begin
          valid_o <= 1'b1;
          value_o <= sat32(W'(gv_q[0]) + h_q);
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/gain_curve_table_interpolator_tb.sv */
// Self-checking bench for the gain curve table interpolator: directed and random
// table builds and queries, checked against a built-in 64-bit prediction.
// Depends on gcti_pkg and the gain_curve_table_interpolator RTL.
module gain_curve_table_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    gcti_pkg::cmd_e cmd;
    logic [31:0]    freq;
    logic [31:0]    gain;
  } cmd_item_t;

  typedef struct {
    logic [31:0]       value;
    gcti_pkg::status_e status;
    logic              err;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command_i = gcti_pkg::CmdClear;
  logic [31:0] freq_i = '0;
  logic [31:0] gain_i = '0;
  logic        valid_o;
  logic [31:0] value_o;
  logic [1:0]  status_o;
  logic        error_seen_o;

  gain_curve_table_interpolator dut (
    .clk_i, .rst_ni, .start, .busy, .command_i, .freq_i, .gain_i,
    .valid_o, .value_o, .status_o, .error_seen_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cmd_item_t   pending_cmds[$];
  answer_t     answers_due[$];
  logic [31:0] curve_freq[gcti_pkg::TableDepth];
  logic [31:0] curve_gain[gcti_pkg::TableDepth];
  int unsigned curve_len = 0;
  bit          curve_err = 1'b0;
  int          mismatches = 0;
  bit          took = 1'b0;
  int          gap_left = 0;
  bit          calm = 1'b0;
  int          idle_cycles = 0;

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? 64'd0 - longint'(v) : v;
  endfunction

  function automatic longint signed_cap(longint unsigned m, bit neg, longint unsigned cap);
    if (m > cap) m = cap;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned round_div(longint unsigned num, longint unsigned den);
    longint unsigned r;
    r = num % den;
    return num / den + ((r >= den - r) ? 64'd1 : 64'd0);
  endfunction

  function automatic longint side_slope(longint dg, longint unsigned df, longint unsigned unit);
    return signed_cap(round_div(mag64(dg) * unit, df), dg < 0, gcti_pkg::SlopeCap);
  endfunction

  function automatic longint hermite_tangent(longint p, longint q);
    longint unsigned a, b, x;
    if (p == 0 || q == 0 || ((p < 0) != (q < 0))) return 0;
    a = mag64(p);
    b = mag64(q);
    x = (a < b) ? a : b;
    return signed_cap(64'd2 * (x - round_div(x * x, a + b)), q < 0, gcti_pkg::SlopeCap);
  endfunction

  function automatic longint scale_q32(longint v, longint unsigned pos);
    longint unsigned m, r;
    m = mag64(v);
    r = (m >> 32) * pos + (((m & 64'hFFFF_FFFF) * pos + 64'h8000_0000) >> 32);
    return signed_cap(r, v < 0, gcti_pkg::WideMax);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] curve_gain_at(longint f, bit cubic);
    int unsigned lo, hi, mid, i;
    longint f0, f1, g0, g1, m0, m1, m2, t0, t1, ca, cb, h, num;
    longint unsigned unit, d0, d1, pos;
    if (curve_len == 0) return '0;
    if (f <= longint'($signed(curve_freq[0]))) return curve_gain[0];
    if (f >= longint'($signed(curve_freq[curve_len-1]))) return curve_gain[curve_len-1];
    lo = 0;
    hi = curve_len - 1;
    while (hi - lo > 1) begin
      mid = lo + (hi - lo) / 2;
      if (longint'($signed(curve_freq[mid])) <= f) lo = mid;
      else hi = mid;
    end
    i = lo;
    f0 = $signed(curve_freq[i]);
    f1 = $signed(curve_freq[i+1]);
    g0 = $signed(curve_gain[i]);
    g1 = $signed(curve_gain[i+1]);
    unit = f1 - f0;
    d0 = f - f0;
    d1 = f1 - f;
    if (!cubic) begin
      if (d0 == 0) return g0[31:0];
      num = longint'(d0) * g1 + longint'(d1) * g0;
      return clamp32(signed_cap(round_div(mag64(num), unit), num < 0, gcti_pkg::WideMax));
    end
    m1 = g1 - g0;
    m0 = 0;
    if (i > 0)
      m0 = side_slope(g0 - longint'($signed(curve_gain[i-1])),
                      f0 - longint'($signed(curve_freq[i-1])), unit);
    m2 = 0;
    if (i + 2 < curve_len)
      m2 = side_slope(longint'($signed(curve_gain[i+2])) - g1,
                      longint'($signed(curve_freq[i+2])) - f1, unit);
    t0 = hermite_tangent(m0, m1);
    t1 = hermite_tangent(m1, m2);
    ca = t0 + t1 - 2 * m1;
    cb = 3 * m1 - t1 - 2 * t0;
    pos = round_div(d0 << 32, unit);
    h = scale_q32(ca, pos) + cb;
    h = scale_q32(h, pos) + t0;
    h = scale_q32(h, pos);
    return clamp32(g0 + h);
  endfunction

  function automatic answer_t apply_command(cmd_item_t it);
    answer_t a;
    a.value = '0;
    a.status = gcti_pkg::StatOk;
    case (it.cmd)
      gcti_pkg::CmdClear: begin
        curve_len = 0;
        curve_err = 1'b0;
      end
      gcti_pkg::CmdAppend: begin
        if (curve_len >= gcti_pkg::TableDepth) begin
          a.status = gcti_pkg::StatFull;
          curve_err = 1'b1;
        end else if (curve_len > 0 &&
                     $signed(it.freq) <= $signed(curve_freq[curve_len-1])) begin
          a.status = gcti_pkg::StatOrder;
          curve_err = 1'b1;
        end else begin
          curve_freq[curve_len] = it.freq;
          curve_gain[curve_len] = it.gain;
          curve_len++;
        end
      end
      default: a.value = curve_gain_at($signed(it.freq), it.cmd == gcti_pkg::CmdCubic);
    endcase
    a.err = curve_err;
    return a;
  endfunction

  function automatic void add_cmd(gcti_pkg::cmd_e c, logic [31:0] f, logic [31:0] g);
    cmd_item_t it;
    it.cmd = c;
    it.freq = f;
    it.gain = g;
    pending_cmds.push_back(it);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: hold an item until its transfer, then advance
  always @(negedge clk_i) begin
    cmd_item_t it;
    if (rst_ni && !(start && !took)) begin
      took = 1'b0;
      if ($urandom_range(0, 199) == 0) calm = !calm;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        it = pending_cmds.pop_front();
        command_i <= it.cmd;
        freq_i <= it.freq;
        gain_i <= it.gain;
        start <= 1'b1;
        gap_left = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on each command transfer, check each result transfer
  always @(posedge clk_i) begin
    cmd_item_t it;
    answer_t   want;
    if (rst_ni) begin
      idle_cycles++;
      if (start && !busy) begin
        it.cmd = gcti_pkg::cmd_e'(command_i);
        it.freq = freq_i;
        it.gain = gain_i;
        answers_due.push_back(apply_command(it));
        took = 1'b1;
        idle_cycles = 0;
      end
      if (valid_o) begin
        idle_cycles = 0;
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result value=%h", value_o);
        end else begin
          want = answers_due.pop_front();
          if (value_o !== want.value || status_o !== want.status ||
              error_seen_o !== want.err) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp value=%h status=%0d err=%0b got value=%h status=%0d err=%0b",
                       want.value, want.status, want.err, value_o, status_o, error_seen_o);
          end
        end
      end
      if (idle_cycles > 20000) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_query_freq(longint lo_f, longint hi_f);
    int r;
    longint pick;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom();
    if (r == 1) return lo_f[31:0];
    if (r == 2) return hi_f[31:0];
    if (hi_f <= lo_f) return lo_f[31:0];
    pick = lo_f + longint'({$urandom(), $urandom()} % (hi_f - lo_f + 1));
    return pick[31:0];
  endfunction

  initial begin
    longint f, lo_f, step, dup_f;
    int k, q, r;
    add_cmd(gcti_pkg::CmdClear, '0, '0);
    add_cmd(gcti_pkg::CmdLinear, 32'h1234_5678, '0);
    add_cmd(gcti_pkg::CmdCubic, 32'h8000_0000, '0);
    add_cmd(gcti_pkg::CmdAppend, 32'h8000_0000, 32'h7FFF_FFFF);
    add_cmd(gcti_pkg::CmdAppend, 32'h8000_0000, 32'h0000_0001);
    add_cmd(gcti_pkg::CmdAppend, 32'h7FFF_FFFF, 32'h8000_0000);
    add_cmd(gcti_pkg::CmdLinear, 32'h8000_0000, '0);
    add_cmd(gcti_pkg::CmdLinear, 32'h7FFF_FFFF, '0);
    add_cmd(gcti_pkg::CmdLinear, 32'h0000_0000, 32'hFFFF_FFFF);
    add_cmd(gcti_pkg::CmdCubic, 32'hFFFF_FFFF, '0);
    add_cmd(gcti_pkg::CmdClear, '0, '0);
    add_cmd(gcti_pkg::CmdAppend, 32'hFFFF_0000, 32'h0001_0000);
    add_cmd(gcti_pkg::CmdAppend, 32'h0000_0000, 32'h0003_0000);
    add_cmd(gcti_pkg::CmdAppend, 32'h0001_0000, 32'h0002_0000);
    add_cmd(gcti_pkg::CmdAppend, 32'h0002_0000, 32'h0007_0000);
    add_cmd(gcti_pkg::CmdAppend, 32'h0001_8000, 32'h0007_0000);
    add_cmd(gcti_pkg::CmdCubic, 32'hFFFF_8000, '0);
    add_cmd(gcti_pkg::CmdCubic, 32'h0000_8000, '0);
    add_cmd(gcti_pkg::CmdCubic, 32'h0001_4000, '0);
    add_cmd(gcti_pkg::CmdLinear, 32'h0000_0000, '0);
    add_cmd(gcti_pkg::CmdLinear, 32'h0001_C000, '0);
    add_cmd(gcti_pkg::CmdClear, '0, '0);
    while (pending_cmds.size() < 900) begin
      r = $urandom_range(0, 9);
      if (r < 8) begin
        add_cmd(gcti_pkg::CmdClear, $urandom(), $urandom());
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(2, 8);
        step = 64'd1 << $urandom_range(0, 31);
        f = -64'sd2147483648 + longint'($urandom() % 32'h4000_0000);
        if ($urandom_range(0, 3) == 0) f = -64'sd2147483648;
        lo_f = f;
        for (int j = 0; j < k && f <= 64'sd2147483647; j++) begin
          add_cmd(gcti_pkg::CmdAppend, f[31:0], $urandom());
          if ($urandom_range(0, 15) == 0) begin
            dup_f = f - $urandom_range(0, 3);
            add_cmd(gcti_pkg::CmdAppend, dup_f[31:0], $urandom());
          end
          f = f + 1 + longint'({$urandom(), $urandom()} % step);
          if ($urandom_range(0, 15) == 0 && f <= 64'sd2147483647 - 2*step)
            f = 64'sd2147483647;
        end
        q = $urandom_range(2, 10);
        for (int j = 0; j < q; j++) begin
          add_cmd($urandom_range(0, 1) ? gcti_pkg::CmdCubic : gcti_pkg::CmdLinear,
                  pick_query_freq(lo_f, f), $urandom());
        end
      end else begin
        for (int j = 0; j < 5; j++) begin
          add_cmd(gcti_pkg::cmd_e'($urandom_range(1, 3)), $urandom(), $urandom());
        end
      end
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_cmds.size() == 0 && !start && answers_due.size() == 0);
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && answers_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
design/gcti_pkg.sv
design/gcti_ram.sv
design/gcti_div.sv
design/gain_curve_table_interpolator.sv
tb/gain_curve_table_interpolator_tb.sv
